// File: rtl/crt_pkg.sv
// Package for the congruence combiner: widths and defaults.
// No dependencies.
package crt_pkg;
	localparam int MODULUS_BITS_DEF = 62;
	localparam int INPUT_BITS_DEF   = 32;
	localparam int RES_W = 62;
	localparam int MOD_W = 63;
	localparam int IN_W  = 32;
endpackage

// File: rtl/crt_if.sv
// Valid/ready channel interfaces for the congruence combiner.
// Depends on crt_pkg.
interface crt_in_if
	import crt_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] residue;
	logic [IN_W-1:0] modulus;
	logic            restart;
	modport source (output valid, residue, modulus, restart, input ready);
	modport sink   (input valid, residue, modulus, restart, output ready);
endinterface

interface crt_out_if
	import crt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] combined_residue;
	logic [MOD_W-1:0] combined_modulus;
	logic             inconsistent;
	logic             overflow;
	modport source (output valid, combined_residue, combined_modulus, inconsistent, overflow,
		input ready);
	modport sink   (input valid, combined_residue, combined_modulus, inconsistent, overflow,
		output ready);
endinterface

// File: rtl/crt_divu.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on crt_pkg.
module crt_divu
	import crt_pkg::*;
#(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  quo_q, rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;
endmodule

// File: rtl/crt_congruence_combiner_top.sv
// Top level of the congruence combiner: sequencer around one shared divider.
// Depends on crt_pkg, crt_if.sv, crt_divu.sv.
//
// Usage: congruences (residue, modulus, restart) arrive as transactions on in_ch;
// each produces exactly one transaction on out_ch carrying the running residue,
// the lcm modulus and the sticky inconsistent / overflow marks.
// restart=1 first resets the running system to x = 0 (mod 1) and clears marks.
// A modulus of zero is treated as one.
// All division and remainder work is done by one restoring divider of 64 bits
// (one quotient bit per cycle). Per item: reduce residues, Euclid's gcd (one
// division per step, up to ~46 steps on 32-bit values), quotients, extended
// Euclid for the inverse, and a modular product. Multiplications are done
// shift-and-add, one bit per cycle. The work per item grows with the number of
// Euclid steps and multiplier bits; after a failure an item goes straight to
// the output.
// in_ch.ready is high only when the sequencer is idle and no result is pending.
// The result is held in an output register until out_ch.ready takes it; the
// sequencer waits meanwhile. Reset (arst_n low) returns to x = 0 (mod 1),
// clears marks and drops out_ch.valid.
module crt_congruence_combiner_top
	import crt_pkg::*;
#(
	parameter int MODULUS_BITS = MODULUS_BITS_DEF,
	parameter int INPUT_BITS   = INPUT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	crt_in_if.sink    in_ch,
	crt_out_if.source out_ch
);
	localparam int DW = 64;

	typedef enum logic [4:0] {
		S_IDLE, S_RED_B, S_RED_R, S_GCD, S_DIFF, S_DIVD, S_QMQ, S_CHK,
		S_MQ_MOD, S_EE, S_EE_UPD, S_SMOD, S_KT, S_KTMOD, S_MR, S_OUT
	} state_t;

	state_t state_q;
	logic [RES_W-1:0] acc_r_q;
	logic [MOD_W-1:0] acc_m_q;
	logic failed_q, ovf_q;
	logic [DW-1:0] m_q, br_q, ar_q, ga_q, gb_q, diff_q, d_q, mq_q, bigm_q, k_q;
	logic signed [DW-1:0] r0_q, r1_q, s0_q, s1_q;
	logic [DW-1:0] inv_q;
	// new lcm, kept from the overflow check
	logic [MOD_W-1:0] lcm_q;
	// shift-and-add multiplier
	logic [127:0] pa_q, pacc_q;
	logic [DW-1:0] pb_q;
	logic mul_busy_q;
	logic div_start;
	logic [DW-1:0] div_num, div_den, div_quo, div_rem;
	logic div_done;
	logic div_wait_q;
	logic [DW-1:0] in_mask;
	logic [127:0] lim;

	assign in_mask = (DW'(1) << INPUT_BITS) - DW'(1);
	assign lim = 128'(1) << MODULUS_BITS;

	crt_divu #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	assign in_ch.ready = (state_q == S_IDLE) && !out_ch.valid;
	assign out_ch.combined_residue = (failed_q || ovf_q) ? '0 : acc_r_q;
	assign out_ch.combined_modulus = acc_m_q;
	assign out_ch.inconsistent = failed_q;
	assign out_ch.overflow = ovf_q;

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = DW'(1);
		if (!div_wait_q && !mul_busy_q) begin
			case (state_q)
				S_RED_B: begin div_start = 1'b1; div_num = br_q; div_den = m_q; end
				S_RED_R: begin div_start = 1'b1; div_num = DW'(acc_r_q); div_den = m_q; end
				S_GCD: begin
					div_start = (gb_q != '0); div_num = ga_q; div_den = gb_q;
				end
				S_DIVD: begin div_start = 1'b1; div_num = diff_q; div_den = d_q; end
				S_QMQ: begin div_start = 1'b1; div_num = m_q; div_den = d_q; end
				S_CHK: begin div_start = 1'b1; div_num = DW'(acc_m_q); div_den = d_q; end
				S_MQ_MOD: begin
					div_start = (pacc_q <= lim); div_num = bigm_q; div_den = mq_q;
				end
				S_EE: begin
					div_start = (r1_q != '0); div_num = r0_q; div_den = r1_q;
				end
				S_KTMOD: begin div_start = 1'b1; div_num = pacc_q[DW-1:0]; div_den = mq_q; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_r_q <= '0;
			acc_m_q <= MOD_W'(1);
			failed_q <= 1'b0;
			ovf_q <= 1'b0;
			out_ch.valid <= 1'b0;
			div_wait_q <= 1'b0;
			mul_busy_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			if (div_start) div_wait_q <= 1'b1;
			if (div_done) div_wait_q <= 1'b0;
			if (mul_busy_q) begin
				if (pb_q[0]) pacc_q <= pacc_q + pa_q;
				pa_q <= pa_q << 1;
				pb_q <= pb_q >> 1;
				if (pb_q == '0) mul_busy_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					if (in_ch.restart) begin
						acc_r_q <= '0; acc_m_q <= MOD_W'(1);
						failed_q <= 1'b0; ovf_q <= 1'b0;
					end
					br_q <= DW'(in_ch.residue) & in_mask;
					m_q <= ((DW'(in_ch.modulus) & in_mask) == '0) ? DW'(1)
						: (DW'(in_ch.modulus) & in_mask);
					if ((failed_q || ovf_q) && !in_ch.restart) state_q <= S_OUT;
					else state_q <= S_RED_B;
				end
				S_RED_B: if (div_done) begin br_q <= div_rem; state_q <= S_RED_R; end
				S_RED_R: if (div_done) begin
					ar_q <= div_rem;
					ga_q <= DW'(acc_m_q); gb_q <= m_q;
					state_q <= S_GCD;
				end
				S_GCD: if (!div_wait_q && gb_q == '0) begin
					d_q <= ga_q;
					diff_q <= (br_q >= ar_q) ? br_q - ar_q : br_q + m_q - ar_q;
					state_q <= S_DIVD;
				end else if (div_done) begin
					ga_q <= gb_q; gb_q <= div_rem;
				end
				S_DIVD: if (div_done) begin
					if (div_rem != '0) begin failed_q <= 1'b1; state_q <= S_OUT; end
					else begin k_q <= div_quo; state_q <= S_QMQ; end
				end
				S_QMQ: if (div_done) begin mq_q <= div_quo; state_q <= S_CHK; end
				S_CHK: if (div_done) begin
					bigm_q <= div_quo;
					// product acc_m * mq
					pa_q <= 128'(acc_m_q); pb_q <= mq_q; pacc_q <= '0;
					mul_busy_q <= 1'b1;
					state_q <= S_MQ_MOD;
				end
				S_MQ_MOD: if (!mul_busy_q && !div_wait_q && pacc_q > lim) begin
					ovf_q <= 1'b1; state_q <= S_OUT;
				end else if (div_done) begin
					lcm_q <= pacc_q[MOD_W-1:0];
					r0_q <= div_rem; r1_q <= mq_q;
					s0_q <= DW'(1); s1_q <= '0;
					state_q <= S_EE;
				end
				S_EE: if (!div_wait_q && r1_q == '0) begin
					inv_q <= (mq_q <= DW'(1)) ? '0
						: (s0_q < 0 ? s0_q + $signed(mq_q) : s0_q);
					state_q <= S_KT;
				end else if (div_done) begin
					r0_q <= r1_q; r1_q <= div_rem;
					// quotient * s1 by shift-add
					pa_q <= 128'(div_quo); pb_q <= s1_q; pacc_q <= '0;
					mul_busy_q <= 1'b1;
					state_q <= S_EE_UPD;
				end
				S_EE_UPD: if (!mul_busy_q) begin
					s0_q <= s1_q; s1_q <= s0_q - $signed(pacc_q[DW-1:0]);
					state_q <= S_EE;
				end
				S_KT: begin
					pa_q <= 128'(k_q); pb_q <= inv_q; pacc_q <= '0;
					mul_busy_q <= 1'b1;
					state_q <= S_KTMOD;
				end
				S_KTMOD: if (div_done) begin
					pa_q <= 128'(acc_m_q); pb_q <= div_rem; pacc_q <= '0;
					mul_busy_q <= 1'b1;
					state_q <= S_MR;
				end
				S_MR: if (!mul_busy_q) begin
					acc_r_q <= RES_W'(DW'(acc_r_q) + pacc_q[DW-1:0]);
					acc_m_q <= lcm_q;
					state_q <= S_OUT;
				end
				S_OUT: begin out_ch.valid <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/crt_checker.sv
// Port-level checks for the congruence combiner; bound to the top level.
// Depends on crt_if.sv and crt_congruence_combiner_top.
module crt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid, in_ready, out_valid, out_ready,
	input logic inconsistent, overflow,
	input logic [61:0] combined_residue
);
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (inconsistent || overflow) |-> combined_residue == '0)
		else $error("failed result carries nonzero residue");
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind crt_congruence_combiner_top crt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.inconsistent(out_ch.inconsistent), .overflow(out_ch.overflow),
	.combined_residue(out_ch.combined_residue)
);
